[rtl/i2cm_pkg.sv]
// i2cm_pkg: shared types, codes and helpers of the i2c master bit engine
package i2cm_pkg;

  // request codes carried in req_type
  localparam logic [2:0] REQ_TICK     = 3'd0;
  localparam logic [2:0] REQ_START    = 3'd1;
  localparam logic [2:0] REQ_STOP     = 3'd2;
  localparam logic [2:0] REQ_WRITE    = 3'd3;
  localparam logic [2:0] REQ_WAIT_ACK = 3'd4;
  localparam logic [2:0] REQ_READ     = 3'd5;

  // configuration register indexes (word address bit 2)
  localparam logic REG_TICKS_PER_UNIT = 1'b0;
  localparam logic REG_ACK_TIMEOUT    = 1'b1;

  localparam int unsigned PADDR_W = 3;

  // configuration reset values
  localparam logic [15:0] TICKS_PER_UNIT_RST = 16'd1;
  localparam logic [7:0]  ACK_TIMEOUT_RST    = 8'd250;

  // bus timing segment lengths in delay units
  localparam logic [2:0] UNITS_1 = 3'd1;
  localparam logic [2:0] UNITS_2 = 3'd2;
  localparam logic [2:0] UNITS_5 = 3'd5;
  localparam logic [2:0] UNITS_6 = 3'd6;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_ST1,
    PH_ST2,
    PH_SP1,
    PH_SP2,
    PH_WR_HI,
    PH_WR_LO,
    PH_AK1,
    PH_AK2,
    PH_AK_POLL,
    PH_RD_LO,
    PH_RD_HI,
    PH_RA_LO,
    PH_RA_HI
  } phase_t;

  // sequencer state
  typedef struct packed {
    phase_t      phase;
    logic [3:0]  bit_count;
    logic [7:0]  shift_byte;
    logic [23:0] delay_count;
    logic [7:0]  poll_count;
    logic        scl;
    logic        sda;
    logic        drive;
    logic        ack_mode;
    logic [7:0]  received_byte;
    logic        error_flag;
  } state_t;

  // one result item
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy;
    logic       done;
    logic [7:0] read_data;
    logic       ack_error;
    logic       rejected;
  } result_t;

  // segment length in ticks: at most 6 * 65535, fits 24 bits
  function automatic logic [23:0] delay_ticks(input logic [2:0] units,
                                              input logic [15:0] tpu);
    logic [18:0] prod;
    prod = 19'(units) * 19'(tpu);
    return 24'(prod);
  endfunction

endpackage

[rtl/i2cm_seq.sv]
// i2cm_seq: next-state and result logic for one item of the bit engine
module i2cm_seq (
  input  i2cm_pkg::state_t  cur,
  input  logic [2:0]        req_type,
  input  logic [7:0]        data_byte,
  input  logic              send_ack,
  input  logic              sda_sample,
  input  logic [15:0]       ticks_per_unit,
  input  logic [7:0]        ack_timeout,
  output i2cm_pkg::state_t  nxt,
  output i2cm_pkg::result_t res
);

  logic rej;
  logic tick_end;

  // shift out the next data bit with scl high
  function automatic i2cm_pkg::state_t write_bit(input i2cm_pkg::state_t s,
                                                 input logic [15:0] tpu);
    i2cm_pkg::state_t r;
    r            = s;
    r.sda        = s.shift_byte[7];
    r.shift_byte = {s.shift_byte[6:0], 1'b0};
    r.scl        = 1'b1;
    r.delay_count = i2cm_pkg::delay_ticks(i2cm_pkg::UNITS_2, tpu);
    r.phase      = i2cm_pkg::PH_WR_HI;
    return r;
  endfunction

  // stop condition: scl high, sda low, then sda rises
  function automatic i2cm_pkg::state_t begin_stop(input i2cm_pkg::state_t s,
                                                  input logic [15:0] tpu);
    i2cm_pkg::state_t r;
    r             = s;
    r.drive       = 1'b1;
    r.scl         = 1'b1;
    r.sda         = 1'b0;
    r.delay_count = i2cm_pkg::delay_ticks(i2cm_pkg::UNITS_6, tpu);
    r.phase       = i2cm_pkg::PH_SP1;
    return r;
  endfunction

  // one poll of sda during the acknowledge wait
  function automatic i2cm_pkg::state_t poll_ack(input i2cm_pkg::state_t s,
                                                input logic sample,
                                                input logic [7:0] ato,
                                                input logic [15:0] tpu);
    i2cm_pkg::state_t r;
    r = s;
    if (!sample) begin
      r.scl   = 1'b0;
      r.phase = i2cm_pkg::PH_IDLE;
    end else if (s.poll_count >= ato) begin
      r            = begin_stop(s, tpu);
      r.error_flag = 1'b1;
    end else begin
      r.poll_count = s.poll_count + 8'd1;
    end
    return r;
  endfunction

  // actions at the end of a timed segment
  function automatic i2cm_pkg::state_t seg_end(input i2cm_pkg::state_t s,
                                               input logic sample,
                                               input logic [7:0] ato,
                                               input logic [15:0] tpu);
    i2cm_pkg::state_t r;
    r = s;
    unique case (s.phase)
      i2cm_pkg::PH_ST1: begin
        r.sda         = 1'b0;
        r.delay_count = i2cm_pkg::delay_ticks(i2cm_pkg::UNITS_6, tpu);
        r.phase       = i2cm_pkg::PH_ST2;
      end
      i2cm_pkg::PH_ST2: begin
        r.scl   = 1'b0;
        r.phase = i2cm_pkg::PH_IDLE;
      end
      i2cm_pkg::PH_SP1: begin
        r.sda         = 1'b1;
        r.delay_count = i2cm_pkg::delay_ticks(i2cm_pkg::UNITS_6, tpu);
        r.phase       = i2cm_pkg::PH_SP2;
      end
      i2cm_pkg::PH_SP2: begin
        r.phase = i2cm_pkg::PH_IDLE;
      end
      i2cm_pkg::PH_WR_HI: begin
        r.scl         = 1'b0;
        r.delay_count = i2cm_pkg::delay_ticks(i2cm_pkg::UNITS_2, tpu);
        r.phase       = i2cm_pkg::PH_WR_LO;
      end
      i2cm_pkg::PH_WR_LO: begin
        r.bit_count = s.bit_count + 4'd1;
        if (r.bit_count < i2cm_pkg::BITS_PER_BYTE) begin
          r = write_bit(r, tpu);
        end else begin
          r.phase = i2cm_pkg::PH_IDLE;
        end
      end
      i2cm_pkg::PH_AK1: begin
        r.scl         = 1'b1;
        r.delay_count = i2cm_pkg::delay_ticks(i2cm_pkg::UNITS_1, tpu);
        r.phase       = i2cm_pkg::PH_AK2;
      end
      i2cm_pkg::PH_AK2: begin
        r = poll_ack(s, sample, ato, tpu);
        if (r.phase == i2cm_pkg::PH_AK2) begin
          r.phase = i2cm_pkg::PH_AK_POLL;
        end
      end
      i2cm_pkg::PH_RD_LO: begin
        r.scl         = 1'b1;
        r.shift_byte  = {s.shift_byte[6:0], sample};
        r.delay_count = i2cm_pkg::delay_ticks(i2cm_pkg::UNITS_1, tpu);
        r.phase       = i2cm_pkg::PH_RD_HI;
      end
      i2cm_pkg::PH_RD_HI: begin
        r.bit_count   = s.bit_count + 4'd1;
        r.scl         = 1'b0;
        r.delay_count = i2cm_pkg::delay_ticks(i2cm_pkg::UNITS_2, tpu);
        if (r.bit_count < i2cm_pkg::BITS_PER_BYTE) begin
          r.phase = i2cm_pkg::PH_RD_LO;
        end else begin
          r.received_byte = s.shift_byte;
          r.drive         = 1'b1;
          r.sda           = ~s.ack_mode;
          r.phase         = i2cm_pkg::PH_RA_LO;
        end
      end
      i2cm_pkg::PH_RA_LO: begin
        r.scl         = 1'b1;
        r.delay_count = i2cm_pkg::delay_ticks(i2cm_pkg::UNITS_5, tpu);
        r.phase       = i2cm_pkg::PH_RA_HI;
      end
      i2cm_pkg::PH_RA_HI: begin
        r.scl   = 1'b0;
        r.phase = i2cm_pkg::PH_IDLE;
      end
      default: begin
        r.phase = i2cm_pkg::PH_IDLE;
      end
    endcase
    return r;
  endfunction

  // next state
  always_comb begin
    nxt      = cur;
    rej      = 1'b0;
    tick_end = 1'b0;
    unique case (req_type)
      i2cm_pkg::REQ_TICK: begin
        if (cur.phase == i2cm_pkg::PH_AK_POLL) begin
          nxt      = poll_ack(cur, sda_sample, ack_timeout, ticks_per_unit);
          tick_end = 1'b1;
        end else if (cur.phase != i2cm_pkg::PH_IDLE) begin
          tick_end = 1'b1;
          if (cur.delay_count > 24'd1) begin
            nxt.delay_count = cur.delay_count - 24'd1;
          end else begin
            nxt = seg_end(cur, sda_sample, ack_timeout, ticks_per_unit);
          end
        end
      end
      i2cm_pkg::REQ_START, i2cm_pkg::REQ_STOP, i2cm_pkg::REQ_WRITE,
      i2cm_pkg::REQ_WAIT_ACK, i2cm_pkg::REQ_READ: begin
        if (cur.phase != i2cm_pkg::PH_IDLE) begin
          rej = 1'b1;
        end else begin
          nxt.error_flag = 1'b0;
          unique case (req_type)
            i2cm_pkg::REQ_START: begin
              nxt.drive       = 1'b1;
              nxt.sda         = 1'b1;
              nxt.scl         = 1'b1;
              nxt.delay_count = i2cm_pkg::delay_ticks(i2cm_pkg::UNITS_5,
                                                      ticks_per_unit);
              nxt.phase       = i2cm_pkg::PH_ST1;
            end
            i2cm_pkg::REQ_STOP: begin
              nxt = begin_stop(nxt, ticks_per_unit);
            end
            i2cm_pkg::REQ_WRITE: begin
              nxt.drive      = 1'b1;
              nxt.scl        = 1'b0;
              nxt.shift_byte = data_byte;
              nxt.bit_count  = 4'd0;
              nxt            = write_bit(nxt, ticks_per_unit);
            end
            i2cm_pkg::REQ_WAIT_ACK: begin
              nxt.drive       = 1'b0;
              nxt.sda         = 1'b1;
              nxt.poll_count  = 8'd0;
              nxt.delay_count = i2cm_pkg::delay_ticks(i2cm_pkg::UNITS_1,
                                                      ticks_per_unit);
              nxt.phase       = i2cm_pkg::PH_AK1;
            end
            default: begin
              nxt.drive       = 1'b0;
              nxt.scl         = 1'b0;
              nxt.shift_byte  = 8'd0;
              nxt.bit_count   = 4'd0;
              nxt.ack_mode    = send_ack;
              nxt.delay_count = i2cm_pkg::delay_ticks(i2cm_pkg::UNITS_2,
                                                      ticks_per_unit);
              nxt.phase       = i2cm_pkg::PH_RD_LO;
            end
          endcase
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

  // result item seen after the item is applied
  always_comb begin
    res.scl_level = nxt.scl;
    res.sda_level = nxt.drive ? nxt.sda : 1'b1;
    res.sda_drive = nxt.drive;
    res.busy      = (nxt.phase != i2cm_pkg::PH_IDLE);
    res.done      = tick_end && (nxt.phase == i2cm_pkg::PH_IDLE);
    res.read_data = nxt.received_byte;
    res.ack_error = nxt.error_flag;
    res.rejected  = rej;
  end

endmodule

[rtl/i2c_master_bit_engine.sv]
// i2c_master_bit_engine: i2c master pin sequencer, top level
//
// Input channel (in_*): one item per handshake, either a time tick carrying
// the sampled sda level or a command (start, stop, write byte, wait for
// acknowledge, read byte). Each accepted item yields exactly one result item
// on the output channel (out_*) with the pin levels, busy/done flags, the
// last read byte, the acknowledge error flag and a rejected flag.
// The result of an item is registered and shown in the cycle after the item
// is accepted. Throughput is one item per cycle while in_stall is low; the
// whole step of the sequencer is one pass of logic between the state and the
// result register. While the result register holds an untaken result and
// out_stall is high, in_stall is raised and the state holds; the item being
// taken in the same cycle frees the slot for the next one.
// Bus timing counts tick items: segments of 5, 6, 2 and 1 units, each of
// ticks_per_unit ticks, set over the apb-style port with ack_timeout. The
// user writes configuration only while idle; the block does not enforce it.
// Reset (rst_n low, synchronous) returns the sequencer to idle with scl and
// sda driven high, clears the flags and restores the register defaults.
module i2c_master_bit_engine (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [2:0]                     in_req_type,
  input  logic [7:0]                     in_data_byte,
  input  logic                           in_send_ack,
  input  logic                           in_sda_sample,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_scl_level,
  output logic                           out_sda_level,
  output logic                           out_sda_drive,
  output logic                           out_busy_res,
  output logic                           out_done_res,
  output logic [7:0]                     out_read_data,
  output logic                           out_ack_error,
  output logic                           out_rejected,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [i2cm_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  i2cm_pkg::state_t  state_r;
  i2cm_pkg::state_t  state_nxt;
  i2cm_pkg::result_t res_r;
  i2cm_pkg::result_t res_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [15:0]       tpu_r;
  logic [7:0]        ack_to_r;
  logic              in_acc;
  logic              cfg_wr;

  // handshake
  assign in_stall      = out_valid_r && out_stall;
  assign in_acc        = in_valid && !in_stall;
  assign out_valid_nxt = in_acc || (out_valid_r && out_stall);

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpu_r    <= i2cm_pkg::TICKS_PER_UNIT_RST;
      ack_to_r <= i2cm_pkg::ACK_TIMEOUT_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == i2cm_pkg::REG_TICKS_PER_UNIT) begin
        tpu_r <= pwdata[15:0];
      end else begin
        ack_to_r <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == i2cm_pkg::REG_ACK_TIMEOUT) begin
      prdata = {24'd0, ack_to_r};
    end else begin
      prdata = {16'd0, tpu_r};
    end
  end

  // sequencer step
  i2cm_seq u_seq (
    .cur            (state_r),
    .req_type       (in_req_type),
    .data_byte      (in_data_byte),
    .send_ack       (in_send_ack),
    .sda_sample     (in_sda_sample),
    .ticks_per_unit (tpu_r),
    .ack_timeout    (ack_to_r),
    .nxt            (state_nxt),
    .res            (res_nxt)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase         <= i2cm_pkg::PH_IDLE;
      state_r.bit_count     <= 4'd0;
      state_r.shift_byte    <= 8'd0;
      state_r.delay_count   <= 24'd0;
      state_r.poll_count    <= 8'd0;
      state_r.scl           <= 1'b1;
      state_r.sda           <= 1'b1;
      state_r.drive         <= 1'b1;
      state_r.ack_mode      <= 1'b0;
      state_r.received_byte <= 8'd0;
      state_r.error_flag    <= 1'b0;
    end else if (in_acc) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_scl_level = res_r.scl_level;
  assign out_sda_level = res_r.sda_level;
  assign out_sda_drive = res_r.sda_drive;
  assign out_busy_res  = res_r.busy;
  assign out_done_res  = res_r.done;
  assign out_read_data = res_r.read_data;
  assign out_ack_error = res_r.ack_error;
  assign out_rejected  = res_r.rejected;

endmodule

[rtl/i2cm_checker.sv]
// i2cm_checker: port-level assertions for the i2c master bit engine, with bind
module i2cm_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_stall,
  input logic out_scl_level,
  input logic out_sda_level,
  input logic out_sda_drive,
  input logic out_busy_res,
  input logic out_done_res,
  input logic out_ack_error,
  input logic out_rejected
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a finished sequence leaves the engine idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res)
    else $error("done reported while still busy");

  // a rejected command never completes a sequence
  a_rej_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rejected |-> !out_done_res && out_busy_res)
    else $error("rejected item shows completion or idle engine");

  // a timed-out acknowledge ends in a stop with both lines driven high
  a_err_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res && out_ack_error
      |-> out_scl_level && out_sda_level && out_sda_drive)
    else $error("acknowledge timeout did not end with a stop");

endmodule

bind i2c_master_bit_engine i2cm_checker u_i2cm_checker (.*);

[tb/i2c_master_bit_engine_tb.sv]
// i2c_master_bit_engine_tb: self-checking testbench for the i2c master bit engine
`timescale 1ns / 100ps

module i2c_master_bit_engine_tb;
  import i2cm_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int LONG_HOLD      = 80;
  localparam int RANDOM_QUOTA   = 75;
  localparam int LONG_TPU_TICKS = 20;
  // codes outside the request set
  localparam logic [2:0] REQ_UNUSED_6 = 3'd6;
  localparam logic [2:0] REQ_UNUSED_7 = 3'd7;

  typedef struct packed {
    logic [2:0] req;
    logic [7:0] data;
    logic       ack;
    logic       sda;
  } bus_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_req_type = REQ_TICK;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_send_ack = 1'b0;
  logic        in_sda_sample = 1'b1;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_scl_level;
  logic        out_sda_level;
  logic        out_sda_drive;
  logic        out_busy_res;
  logic        out_done_res;
  logic [7:0]  out_read_data;
  logic        out_ack_error;
  logic        out_rejected;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  i2c_master_bit_engine dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_data_byte  (in_data_byte),
    .in_send_ack   (in_send_ack),
    .in_sda_sample (in_sda_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_scl_level (out_scl_level),
    .out_sda_level (out_sda_level),
    .out_sda_drive (out_sda_drive),
    .out_busy_res  (out_busy_res),
    .out_done_res  (out_done_res),
    .out_read_data (out_read_data),
    .out_ack_error (out_ack_error),
    .out_rejected  (out_rejected),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  bus_item_t item_q[$];
  result_t   awaited_pins[$];
  bus_item_t next_item;
  int        stim_count = 0;
  int        fail_count = 0;
  int        send_idle_pct = 17;
  int        recv_idle_pct = 59;
  int        hold_asked = 0;
  int        hold_seen = 0;
  int        hold_left = 0;
  int        quiet_cycles = 0;

  // sequencer copy used for prediction
  phase_t      m_phase = PH_IDLE;
  logic [3:0]  m_bits = 4'd0;
  logic [7:0]  m_shift = 8'h00;
  logic [23:0] m_delay = 24'd0;
  logic [7:0]  m_polls = 8'h00;
  logic        m_scl = 1'b1;
  logic        m_sda = 1'b1;
  logic        m_drive = 1'b1;
  logic        m_ack_mode = 1'b0;
  logic [7:0]  m_rx = 8'h00;
  logic        m_err = 1'b0;
  logic        m_done = 1'b0;
  logic [15:0] m_tpu = TICKS_PER_UNIT_RST;
  logic [7:0]  m_timeout = ACK_TIMEOUT_RST;

  function automatic void load_units(input int units);
    m_delay = 24'(units * int'(m_tpu));
  endfunction

  function automatic void finish_seq();
    m_phase = PH_IDLE;
    m_done = 1'b1;
  endfunction

  function automatic void shift_out_bit();
    m_sda = m_shift[7];
    m_shift = {m_shift[6:0], 1'b0};
    m_scl = 1'b1;
    load_units(UNITS_2);
    m_phase = PH_WR_HI;
  endfunction

  function automatic void begin_stop_seg();
    m_drive = 1'b1;
    m_scl = 1'b1;
    m_sda = 1'b0;
    load_units(UNITS_6);
    m_phase = PH_SP1;
  endfunction

  // one acknowledge poll: low ends the wait, too many highs force a stop
  function automatic void poll_sda(input logic sample);
    if (!sample) begin
      m_scl = 1'b0;
      finish_seq();
    end else if (m_polls >= m_timeout) begin
      m_err = 1'b1;
      begin_stop_seg();
    end else begin
      m_polls = m_polls + 8'd1;
    end
  endfunction

  function automatic void end_segment(input logic sample);
    case (m_phase)
      PH_ST1: begin
        m_sda = 1'b0;
        load_units(UNITS_6);
        m_phase = PH_ST2;
      end
      PH_ST2: begin
        m_scl = 1'b0;
        finish_seq();
      end
      PH_SP1: begin
        m_sda = 1'b1;
        load_units(UNITS_6);
        m_phase = PH_SP2;
      end
      PH_SP2: finish_seq();
      PH_WR_HI: begin
        m_scl = 1'b0;
        load_units(UNITS_2);
        m_phase = PH_WR_LO;
      end
      PH_WR_LO: begin
        m_bits = m_bits + 4'd1;
        if (m_bits < BITS_PER_BYTE) shift_out_bit();
        else finish_seq();
      end
      PH_AK1: begin
        m_scl = 1'b1;
        load_units(UNITS_1);
        m_phase = PH_AK2;
      end
      PH_AK2: begin
        m_phase = PH_AK_POLL;
        poll_sda(sample);
      end
      PH_RD_LO: begin
        m_scl = 1'b1;
        m_shift = {m_shift[6:0], sample};
        load_units(UNITS_1);
        m_phase = PH_RD_HI;
      end
      PH_RD_HI: begin
        m_bits = m_bits + 4'd1;
        m_scl = 1'b0;
        if (m_bits < BITS_PER_BYTE) begin
          load_units(UNITS_2);
          m_phase = PH_RD_LO;
        end else begin
          m_rx = m_shift;
          m_drive = 1'b1;
          m_sda = !m_ack_mode;
          load_units(UNITS_2);
          m_phase = PH_RA_LO;
        end
      end
      PH_RA_LO: begin
        m_scl = 1'b1;
        load_units(UNITS_5);
        m_phase = PH_RA_HI;
      end
      PH_RA_HI: begin
        m_scl = 0;
        finish_seq();
      end
      default: m_phase = PH_IDLE;
    endcase
  endfunction

  // pin levels and flags after one item
  function automatic result_t sequencer_step(input logic [2:0] req, input logic [7:0] data,
                                             input logic ack, input logic sample);
    result_t r;
    logic    rej;
    rej = 1'b0;
    m_done = 1'b0;
    if (req == REQ_TICK) begin
      if (m_phase == PH_AK_POLL) poll_sda(sample);
      else if (m_phase != PH_IDLE) begin
        if (m_delay > 24'd1) m_delay = m_delay - 24'd1;
        else end_segment(sample);
      end
    end else if (req <= REQ_READ) begin
      if (m_phase != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        m_err = 1'b0;
        case (req)
          REQ_START: begin
            m_drive = 1'b1;
            m_sda = 1'b1;
            m_scl = 1'b1;
            load_units(UNITS_5);
            m_phase = PH_ST1;
          end
          REQ_STOP: begin_stop_seg();
          REQ_WRITE: begin
            m_drive = 1'b1;
            m_scl = 1'b0;
            m_shift = data;
            m_bits = 4'd0;
            shift_out_bit();
          end
          REQ_WAIT_ACK: begin
            m_drive = 1'b0;
            m_sda = 1'b1;
            m_polls = 8'h00;
            load_units(UNITS_1);
            m_phase = PH_AK1;
          end
          default: begin
            m_drive = 1'b0;
            m_scl = 1'b0;
            m_shift = 8'h00;
            m_bits = 4'd0;
            m_ack_mode = ack;
            load_units(UNITS_2);
            m_phase = PH_RD_LO;
          end
        endcase
      end
    end
    r.scl_level = m_scl;
    r.sda_level = m_drive ? m_sda : 1'b1;
    r.sda_drive = m_drive;
    r.busy      = (m_phase != PH_IDLE);
    r.done      = m_done;
    r.read_data = m_rx;
    r.ack_error = m_err;
    r.rejected  = rej;
    return r;
  endfunction

  // item driver: holds a stalled item, idles at random when free
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        awaited_pins.push_back(sequencer_step(in_req_type, in_data_byte, in_send_ack,
                                              in_sda_sample));
      end
      if (!in_valid || !in_stall) begin
        if (item_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = item_q.pop_front();
          in_valid <= 1'b1;
          in_req_type <= next_item.req;
          in_data_byte <= next_item.data;
          in_send_ack <= next_item.ack;
          in_sda_sample <= next_item.sda;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_pins();
    result_t want;
    if (awaited_pins.size() == 0) begin
      $error("result item with no item awaiting it");
      fail_count++;
    end else begin
      want = awaited_pins.pop_front();
      check_field("scl_level", want.scl_level, out_scl_level);
      check_field("sda_level", want.sda_level, out_sda_level);
      check_field("sda_drive", want.sda_drive, out_sda_drive);
      check_field("busy_res", want.busy, out_busy_res);
      check_field("done_res", want.done, out_done_res);
      check_field("read_data", want.read_data, out_read_data);
      check_field("ack_error", want.ack_error, out_ack_error);
      check_field("rejected", want.rejected, out_rejected);
    end
  endtask

  // result monitor and receiver stall, with an occasional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_pins();
      if (hold_seen != hold_asked) begin
        hold_seen <= hold_asked;
        hold_left <= LONG_HOLD;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push_item(input logic [2:0] req, input logic [7:0] data, input logic ack,
                           input logic sda);
    bus_item_t it;
    it.req = req;
    it.data = data;
    it.ack = ack;
    it.sda = sda;
    item_q.push_back(it);
    stim_count++;
  endtask

  task automatic push_tick(input logic sda);
    push_item(REQ_TICK, 8'($urandom), 1'($urandom), sda);
  endtask

  // tick not counted as stimulus: spare time or draining a busy sequence
  task automatic push_idle_tick(input logic sda);
    bus_item_t it;
    it.req = REQ_TICK;
    it.data = 8'($urandom);
    it.ack = 1'($urandom);
    it.sda = sda;
    item_q.push_back(it);
  endtask

  function automatic int ticks_of(input int units);
    int n;
    n = units * int'(m_tpu);
    return (n == 0) ? 1 : n;
  endfunction

  // a command and the ticks that carry it through, optionally cut short
  // or with a second request code thrown in while busy
  task automatic run_command(input logic [2:0] req, input logic [7:0] data, input logic ack,
                             input int highs, input bit intrude, input bit cut);
    int n;
    int pos;
    int tail;
    int polls;
    tail = 0;
    polls = highs;
    case (req)
      REQ_START:    n = ticks_of(UNITS_5) + ticks_of(UNITS_6);
      REQ_STOP:     n = 2 * ticks_of(UNITS_6);
      REQ_WRITE:    n = 16 * ticks_of(UNITS_2);
      REQ_WAIT_ACK: n = 2 * ticks_of(UNITS_1) - 1;
      default:      n = 8 * (ticks_of(UNITS_2) + ticks_of(UNITS_1))
                        + ticks_of(UNITS_2) + ticks_of(UNITS_5);
    endcase
    if (cut) n = $urandom_range(n);
    pos = intrude ? $urandom_range(n) : -1;
    push_item(req, data, ack, 1'($urandom));
    for (int i = 0; i < n; i++) begin
      if (i == pos) push_item(3'($urandom_range(1, 7)), 8'($urandom), 1'($urandom),
                              1'($urandom));
      push_tick(1'($urandom));
    end
    // acknowledge polls: highs then a low, or a timeout and its stop
    if (req == REQ_WAIT_ACK && !cut) begin
      if (polls > int'(m_timeout)) begin
        polls = int'(m_timeout) + 1;
        tail = 2 * ticks_of(UNITS_6);
      end
      repeat (polls) push_tick(1'b1);
      if (tail == 0) push_tick(1'b0);
      repeat (tail) push_tick(1'($urandom));
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (item_q.size() != 0 || in_valid || awaited_pins.size() != 0);
  endtask

  // sender pause: all results in, sequencer back to idle
  task automatic settle_idle();
    wait_drained();
    while (m_phase != PH_IDLE) begin
      push_idle_tick(1'b0);
      wait_drained();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic reg_idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_idx == REG_TICKS_PER_UNIT) m_tpu = value[15:0];
    else m_timeout = value[7:0];
  endtask

  task automatic random_traffic(input int quota);
    int goal;
    int pick;
    int highs;
    goal = stim_count + quota;
    while (stim_count < goal) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        // noise: any code, any fields
        push_item(3'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
      end else begin
        pick = $urandom_range(99);
        if (pick < 60) highs = $urandom_range(2);
        else if (pick < 85) highs = $urandom_range(int'(m_timeout));
        else highs = int'(m_timeout) + 1;
        run_command(3'($urandom_range(REQ_START, REQ_READ)), 8'($urandom), 1'($urandom),
                    highs, $urandom_range(99) < 10, $urandom_range(99) < 6);
        repeat ($urandom_range(2)) push_idle_tick(1'($urandom));
      end
    end
  endtask

  // stimulus
  initial begin
    int k;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: idle tick, unknown codes, every command at reset settings
    push_item(REQ_TICK, 8'hA5, 1'b1, 1'b1);
    push_item(REQ_UNUSED_6, 8'hFF, 1'b1, 1'b1);
    push_item(REQ_UNUSED_7, 8'h00, 1'b0, 1'b0);
    run_command(REQ_START, 8'h00, 1'b0, 0, 1'b0, 1'b0);
    run_command(REQ_WRITE, 8'hFF, 1'b0, 0, 1'b1, 1'b0);
    run_command(REQ_WAIT_ACK, 8'h00, 1'b0, 0, 1'b0, 1'b0);
    run_command(REQ_WRITE, 8'h00, 1'b1, 0, 1'b0, 1'b0);
    run_command(REQ_WAIT_ACK, 8'hFF, 1'b1, 3, 1'b1, 1'b0);
    run_command(REQ_READ, 8'h00, 1'b1, 0, 1'b0, 1'b0);
    run_command(REQ_READ, 8'hFF, 1'b0, 0, 1'b0, 1'b0);
    run_command(REQ_STOP, 8'h00, 1'b0, 0, 1'b0, 1'b0);
    // acknowledge timeout with a limit of one, then a command clears the flag
    settle_idle();
    write_reg(REG_ACK_TIMEOUT, 32'd1);
    run_command(REQ_WAIT_ACK, 8'h00, 1'b0, 2, 1'b0, 1'b0);
    run_command(REQ_START, 8'h00, 1'b0, 0, 1'b0, 1'b0);
    // zero ticks per unit: every segment lasts one tick
    settle_idle();
    write_reg(REG_TICKS_PER_UNIT, 32'd0);
    run_command(REQ_WRITE, 8'h5A, 1'b0, 0, 1'b0, 1'b0);
    run_command(REQ_WAIT_ACK, 8'h00, 1'b0, 1, 1'b0, 1'b0);
    run_command(REQ_READ, 8'h00, 1'b1, 0, 1'b0, 1'b0);
    run_command(REQ_STOP, 8'h00, 1'b0, 0, 1'b0, 1'b0);

    // random part under three idling patterns
    for (int mode = 0; mode < 3; mode++) begin
      @(negedge clk);
      send_idle_pct = (mode == 0) ? 17 : (mode == 1) ? 59 : 0;
      recv_idle_pct = (mode == 0) ? 59 : (mode == 1) ? 17 : 0;
      for (int sub = 0; sub < 4; sub++) begin
        k = mode * 4 + sub;
        settle_idle();
        case (k % 4)
          0:       write_reg(REG_TICKS_PER_UNIT, 32'd0);
          1:       write_reg(REG_TICKS_PER_UNIT, 32'd1);
          2:       write_reg(REG_TICKS_PER_UNIT, 32'($urandom_range(2, 3)));
          default: write_reg(REG_TICKS_PER_UNIT, 32'($urandom_range(1, 5)));
        endcase
        case (k % 3)
          0:       write_reg(REG_ACK_TIMEOUT, 32'd1);
          1:       write_reg(REG_ACK_TIMEOUT, 32'($urandom_range(2, 12)));
          default: write_reg(REG_ACK_TIMEOUT, 32'd255);
        endcase
        // long receiver hold-off so the block backs up into its input
        if (sub == 0 && mode != 1) begin
          @(negedge clk);
          hold_asked++;
        end
        random_traffic(RANDOM_QUOTA);
      end
    end

    // largest ticks per unit and acknowledge limit: the opening ticks of a
    // long segment and a command refused while busy
    settle_idle();
    write_reg(REG_TICKS_PER_UNIT, 32'd65535);
    write_reg(REG_ACK_TIMEOUT, 32'd255);
    push_item(REQ_WAIT_ACK, 8'h00, 1'b0, 1'b1);
    repeat (LONG_TPU_TICKS) push_tick(1'b1);
    push_item(REQ_START, 8'h00, 1'b0, 1'b0);
    repeat (LONG_TPU_TICKS) push_tick(1'b0);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0 && awaited_pins.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
